// File: sv/ccvm_pkg.sv
// ----------------------------------------------------------------------------
// ccvm_pkg
// Shared types and constants for the two-sample copula CvM statistic block.
// ----------------------------------------------------------------------------
package ccvm_pkg;

    localparam int COORD_W = 16;
    localparam int STAT_W  = 32;
    localparam int SUM_W   = 48;
    localparam int CFG_W   = 4;

    localparam logic [16:0] ONE_Q16  = 17'h10000;
    localparam logic [16:0] HALF_Q16 = 17'h08000;

    // command from front to back, sized for the largest configuration
    typedef struct packed {
        logic        wr;
        logic        fin;
        logic        grp;
        logic [15:0] addr;
        logic [15:0] data;
        logic [12:0] n;
        logic [12:0] m;
        logic        ovf;
        logic [4:0]  dims;
    } t_cmd;

    typedef struct packed {
        logic busy;
    } t_back_stat;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAIR  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_MUL   = 5'b01000,
        ST_DIV   = 5'b10000
    } t_state;

endpackage

// File: sv/ccvm_front.sv
// ----------------------------------------------------------------------------
// ccvm_front
// Accepts coordinates, tracks row position and group counts, issues commands.
// ----------------------------------------------------------------------------
module ccvm_front #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_DIMS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ccvm_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_grp,
    input  logic [ccvm_pkg::COORD_W-1:0]    i_coord,
    input  logic                            i_last,
    input  logic                            i_q_full,
    output logic                            o_push,
    output ccvm_pkg::t_cmd                  o_cmd
);

    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW  = $clog2(MAX_ROWS + 1);
    localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DMW = $clog2(MAX_DIMS + 1);

    logic [ccvm_pkg::CFG_W-1:0] r_cfg_dims;
    logic                       r_open;
    logic [DMW-1:0]             r_adims;
    logic [DW-1:0]              r_pos;
    logic [CW-1:0]              r_cnt1;
    logic [CW-1:0]              r_cnt2;
    logic                       r_ovf;
    logic                       r_rgrp;
    logic                       r_kept;

    logic [4:0]     cfg5;
    logic [4:0]     clamped;
    logic [DMW-1:0] dims_cur;
    logic           first;
    logic [CW-1:0]  cnt_g;
    logic [CW-1:0]  cnt_row;
    logic           row_grp;
    logic           row_kept;
    logic [DMW:0]   pos_p1;
    logic           row_end;
    logic           accept;
    logic [CW-1:0]  n_cnt1;
    logic [CW-1:0]  n_cnt2;
    logic           n_ovf;
    logic [DW-1:0]  n_pos;

    always_comb begin
        cfg5 = {1'b0, r_cfg_dims};
        if (cfg5 == 5'd0) begin
            clamped = 5'd1;
        end else if (cfg5 > 5'(MAX_DIMS)) begin
            clamped = 5'(MAX_DIMS);
        end else begin
            clamped = cfg5;
        end
        dims_cur = r_open ? r_adims : DMW'(clamped);
        first    = (r_pos == '0);
        cnt_g    = i_grp ? r_cnt2 : r_cnt1;
        row_grp  = first ? i_grp : r_rgrp;
        row_kept = first ? (cnt_g < CW'(MAX_ROWS)) : r_kept;
        cnt_row  = row_grp ? r_cnt2 : r_cnt1;
        pos_p1   = (DMW+1)'(r_pos) + (DMW+1)'(1);
        row_end  = (pos_p1 >= (DMW+1)'(dims_cur));
        n_cnt1   = r_cnt1 + CW'(row_end && row_kept && !row_grp);
        n_cnt2   = r_cnt2 + CW'(row_end && row_kept && row_grp);
        n_ovf    = r_ovf | (first && !row_kept);
        n_pos    = row_end ? '0 : DW'(pos_p1);
    end

    assign accept     = i_in_valid && !i_q_full;
    assign o_in_ready = !i_q_full;
    assign o_push     = accept;

    always_comb begin
        o_cmd      = '0;
        o_cmd.wr   = row_kept;
        o_cmd.fin  = i_last;
        o_cmd.grp  = row_grp;
        o_cmd.addr = 16'({cnt_row[RW-1:0], r_pos});
        o_cmd.data = i_coord;
        o_cmd.n    = 13'(n_cnt1);
        o_cmd.m    = 13'(n_cnt2);
        o_cmd.ovf  = n_ovf;
        o_cmd.dims = 5'(dims_cur);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dims <= ccvm_pkg::CFG_W'(1);
            r_open     <= 1'b0;
            r_adims    <= DMW'(1);
            r_pos      <= '0;
            r_cnt1     <= '0;
            r_cnt2     <= '0;
            r_ovf      <= 1'b0;
            r_rgrp     <= 1'b0;
            r_kept     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_dims <= i_cfg_wdata;
            end
            if (accept) begin
                if (i_last) begin
                    r_open <= 1'b0;
                    r_pos  <= '0;
                    r_cnt1 <= '0;
                    r_cnt2 <= '0;
                    r_ovf  <= 1'b0;
                    r_rgrp <= 1'b0;
                    r_kept <= 1'b0;
                end else begin
                    r_open  <= 1'b1;
                    r_adims <= dims_cur;
                    r_pos   <= n_pos;
                    r_cnt1  <= n_cnt1;
                    r_cnt2  <= n_cnt2;
                    r_ovf   <= n_ovf;
                    r_rgrp  <= row_grp;
                    r_kept  <= row_kept;
                end
            end
        end
    end

endmodule

// File: sv/ccvm_queue.sv
// ----------------------------------------------------------------------------
// ccvm_queue
// Four-entry command queue between front and back.
// ----------------------------------------------------------------------------
module ccvm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ccvm_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ccvm_pkg::t_cmd o_cmd
);

    ccvm_pkg::t_cmd r_mem [4];
    logic [1:0]     r_wp;
    logic [1:0]     r_rp;
    logic [2:0]     r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end

endmodule

// File: sv/ccvm_back.sv
// ----------------------------------------------------------------------------
// ccvm_back
// Row stores, pairwise product pipeline, final scaling and division.
// ----------------------------------------------------------------------------
module ccvm_back #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_DIMS  = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  ccvm_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ccvm_pkg::STAT_W-1:0]   o_stat,
    output logic                          o_empty,
    output logic                          o_drop,
    output ccvm_pkg::t_back_stat          o_bstat
);

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = $clog2(MAX_ROWS + 1);
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DMW   = $clog2(MAX_DIMS + 1);
    localparam int AWD   = RW + DW;
    localparam int DEPTH = MAX_ROWS * (2 ** DW);
    localparam int KW    = 2 * CW + 1;
    localparam int MBW   = (CW + 1 > 16) ? CW + 1 : 16;
    localparam int PRW   = KW + MBW;
    localparam int AW    = PRW + 33;
    localparam int XW0   = AW + FRAC_BITS + 1;
    localparam int XW1   = 3 * CW + 51;
    localparam int XW    = (XW0 > XW1) ? XW0 : XW1;
    localparam int SW    = ccvm_pkg::SUM_W;

    logic [15:0] r_mem1 [DEPTH];
    logic [15:0] r_mem2 [DEPTH];
    logic [15:0] r_rd1a, r_rd1b, r_rd2a, r_rd2b;

    ccvm_pkg::t_state r_state;

    logic [1:0]     r_s;
    logic [RW-1:0]  r_i, r_j;
    logic [DW-1:0]  r_k;
    logic [CW-1:0]  r_n, r_m;
    logic [DMW-1:0] r_dims;
    logic           r_ovf;

    logic           r_t1_v, r_t1_first, r_t1_last;
    logic [1:0]     r_t1_sel;
    logic           r_t2_v, r_t2_last;
    logic [1:0]     r_t2_sel;
    logic [16:0]    r_p;
    logic [SW-1:0]  r_s11, r_s22, r_s12;

    logic [3:0]      r_step;
    logic            r_ph;
    logic [PRW-1:0]  r_prod;
    logic [2*CW-1:0] r_nn, r_mm, r_nm;
    logic [3*CW:0]   r_den0;
    logic [AW-1:0]   r_pos, r_neg;

    logic            r_dinit;
    logic [5:0]      r_dcnt;
    logic [XW-1:0]   r_rem, r_dsh;
    logic [32:0]     r_q;

    logic                        r_out_v;
    logic [ccvm_pkg::STAT_W-1:0] r_stat;
    logic                        r_empty;
    logic                        r_drop;

    logic [CW-1:0]  na, nb;
    logic           k_end, j_end, i_end, s_end;
    logic [AWD-1:0] addr_a, addr_b;
    logic [15:0]    a_v, b_v, mx;
    logic [16:0]    x_v, p_in;
    logic [33:0]    prod34;
    logic [16:0]    n_p;
    logic [KW-1:0]  ma;
    logic [MBW-1:0] mb;
    logic [5:0]     sh;
    logic [AW-1:0]  ext;
    logic           ge;
    logic [32:0]    n_q;
    logic           pop;

    assign pop = (r_state == ccvm_pkg::ST_IDLE) && i_valid && (!i_cmd.fin || !r_out_v);
    assign o_pop        = pop;
    assign o_out_valid  = r_out_v;
    assign o_stat       = r_stat;
    assign o_empty      = r_empty;
    assign o_drop       = r_drop;
    assign o_bstat.busy = (r_state != ccvm_pkg::ST_IDLE);

    always_comb begin
        na     = (r_s == 2'd1) ? r_m : r_n;
        nb     = (r_s == 2'd0) ? r_n : r_m;
        k_end  = (DMW'(r_k) + DMW'(1) == r_dims);
        j_end  = (CW'(r_j) + CW'(1) == nb);
        i_end  = (CW'(r_i) + CW'(1) == na);
        s_end  = (r_s == 2'd2);
        addr_a = {r_i, r_k};
        addr_b = {r_j, r_k};
        a_v    = (r_t1_sel == 2'd1) ? r_rd2a : r_rd1a;
        b_v    = (r_t1_sel == 2'd0) ? r_rd1b : r_rd2b;
        mx     = (a_v > b_v) ? a_v : b_v;
        x_v    = ccvm_pkg::ONE_Q16 - {1'b0, mx};
        p_in   = r_t1_first ? ccvm_pkg::ONE_Q16 : r_p;
        prod34 = p_in * x_v;
        n_p    = 17'((prod34 + 34'(ccvm_pkg::HALF_Q16)) >> 16);
    end

    always_comb begin
        ma = '0;
        mb = '0;
        sh = 6'd0;
        case (r_step)
            4'd0: begin ma = KW'(r_n); mb = MBW'(r_n); end
            4'd1: begin ma = KW'(r_m); mb = MBW'(r_m); end
            4'd2: begin ma = KW'(r_n); mb = MBW'(r_m); end
            4'd3: begin ma = KW'(r_nm); mb = MBW'(r_n) + MBW'(r_m); end
            4'd4: begin ma = KW'(r_mm); mb = MBW'(r_s11[15:0]); sh = 6'd0; end
            4'd5: begin ma = KW'(r_mm); mb = MBW'(r_s11[31:16]); sh = 6'd16; end
            4'd6: begin ma = KW'(r_mm); mb = MBW'(r_s11[47:32]); sh = 6'd32; end
            4'd7: begin ma = KW'(r_nn); mb = MBW'(r_s22[15:0]); sh = 6'd0; end
            4'd8: begin ma = KW'(r_nn); mb = MBW'(r_s22[31:16]); sh = 6'd16; end
            4'd9: begin ma = KW'(r_nn); mb = MBW'(r_s22[47:32]); sh = 6'd32; end
            4'd10: begin ma = {r_nm, 1'b0}; mb = MBW'(r_s12[15:0]); sh = 6'd0; end
            4'd11: begin ma = {r_nm, 1'b0}; mb = MBW'(r_s12[31:16]); sh = 6'd16; end
            4'd12: begin ma = {r_nm, 1'b0}; mb = MBW'(r_s12[47:32]); sh = 6'd32; end
            default: begin ma = '0; mb = '0; sh = 6'd0; end
        endcase
        ext = AW'(r_prod) << sh;
        ge  = (r_rem >= r_dsh);
        n_q = {r_q[31:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.wr) begin
            if (i_cmd.grp) begin
                r_mem2[i_cmd.addr[AWD-1:0]] <= i_cmd.data;
            end else begin
                r_mem1[i_cmd.addr[AWD-1:0]] <= i_cmd.data;
            end
        end
        r_rd1a <= r_mem1[addr_a];
        r_rd1b <= r_mem1[addr_b];
        r_rd2a <= r_mem2[addr_a];
        r_rd2b <= r_mem2[addr_b];
    end

    always_ff @(posedge i_clk) begin
        r_t1_first <= (r_k == '0);
        r_t1_last  <= k_end;
        r_t1_sel   <= r_s;
        r_t2_last  <= r_t1_last;
        r_t2_sel   <= r_t1_sel;
        if (r_t1_v) begin
            r_p <= n_p;
        end
        r_prod <= PRW'(ma * mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ccvm_pkg::ST_IDLE;
            r_out_v <= 1'b0;
            r_t1_v  <= 1'b0;
            r_t2_v  <= 1'b0;
        end else begin
            r_t1_v <= (r_state == ccvm_pkg::ST_PAIR);
            r_t2_v <= r_t1_v;
            if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
            if (r_t2_v && r_t2_last) begin
                case (r_t2_sel)
                    2'd0:    r_s11 <= r_s11 + SW'(r_p);
                    2'd1:    r_s22 <= r_s22 + SW'(r_p);
                    default: r_s12 <= r_s12 + SW'(r_p);
                endcase
            end
            case (r_state)
                ccvm_pkg::ST_IDLE: begin
                    if (pop && i_cmd.fin) begin
                        r_n    <= CW'(i_cmd.n);
                        r_m    <= CW'(i_cmd.m);
                        r_dims <= DMW'(i_cmd.dims);
                        r_ovf  <= i_cmd.ovf;
                        r_s    <= '0;
                        r_i    <= '0;
                        r_j    <= '0;
                        r_k    <= '0;
                        r_s11  <= '0;
                        r_s22  <= '0;
                        r_s12  <= '0;
                        r_pos  <= '0;
                        r_neg  <= '0;
                        if (i_cmd.n == '0 || i_cmd.m == '0) begin
                            r_out_v <= 1'b1;
                            r_stat  <= '0;
                            r_empty <= 1'b1;
                            r_drop  <= i_cmd.ovf;
                        end else begin
                            r_state <= ccvm_pkg::ST_PAIR;
                        end
                    end
                end
                ccvm_pkg::ST_PAIR: begin
                    if (k_end) begin
                        r_k <= '0;
                        if (j_end) begin
                            r_j <= '0;
                            if (i_end) begin
                                r_i <= '0;
                                if (s_end) begin
                                    r_state <= ccvm_pkg::ST_DRAIN;
                                end else begin
                                    r_s <= r_s + 2'd1;
                                end
                            end else begin
                                r_i <= r_i + RW'(1);
                            end
                        end else begin
                            r_j <= r_j + RW'(1);
                        end
                    end else begin
                        r_k <= r_k + DW'(1);
                    end
                end
                ccvm_pkg::ST_DRAIN: begin
                    if (!r_t1_v && !r_t2_v) begin
                        r_state <= ccvm_pkg::ST_MUL;
                        r_step  <= '0;
                        r_ph    <= 1'b0;
                    end
                end
                ccvm_pkg::ST_MUL: begin
                    r_ph <= !r_ph;
                    if (r_ph) begin
                        case (r_step)
                            4'd0:    r_nn   <= (2*CW)'(r_prod);
                            4'd1:    r_mm   <= (2*CW)'(r_prod);
                            4'd2:    r_nm   <= (2*CW)'(r_prod);
                            4'd3:    r_den0 <= (3*CW+1)'(r_prod);
                            4'd10, 4'd11, 4'd12: r_neg <= r_neg + ext;
                            default: r_pos  <= r_pos + ext;
                        endcase
                        if (r_step == 4'd12) begin
                            r_state <= ccvm_pkg::ST_DIV;
                            r_dinit <= 1'b1;
                        end else begin
                            r_step <= r_step + 4'd1;
                        end
                    end
                end
                ccvm_pkg::ST_DIV: begin
                    if (r_dinit) begin
                        r_dinit <= 1'b0;
                        r_dcnt  <= '0;
                        r_q     <= '0;
                        if (!(r_neg < r_pos)) begin
                            r_out_v <= 1'b1;
                            r_stat  <= '0;
                            r_empty <= 1'b0;
                            r_drop  <= r_ovf;
                            r_state <= ccvm_pkg::ST_IDLE;
                        end else begin
                            r_rem <= (XW'(r_pos - r_neg) << FRAC_BITS)
                                   + (XW'(r_den0) << 15);
                            r_dsh <= XW'(r_den0) << 48;
                        end
                    end else begin
                        if (ge) begin
                            r_rem <= r_rem - r_dsh;
                        end
                        r_dsh  <= r_dsh >> 1;
                        r_q    <= n_q;
                        r_dcnt <= r_dcnt + 6'd1;
                        if (r_dcnt == 6'd32) begin
                            r_out_v <= 1'b1;
                            r_stat  <= n_q[32] ? '1 : n_q[31:0];
                            r_empty <= 1'b0;
                            r_drop  <= r_ovf;
                            r_state <= ccvm_pkg::ST_IDLE;
                        end
                    end
                end
                default: r_state <= ccvm_pkg::ST_IDLE;
            endcase
        end
    end

endmodule

// File: sv/copula_cvm_two_sample_statistic.sv
// ----------------------------------------------------------------------------
// copula_cvm_two_sample_statistic
// Two-sample Cramer-von Mises copula statistic over stored pseudo-observations.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_*       in   tdata: coordinate[15:0]; tuser: group; tlast: last
// m_*       out  tdata: statistic[31:0]; tuser: empty_group, rows_dropped
// cfg       in   i_cfg_wdata: dimensions[3:0]
//
// Coordinates are taken at one item per cycle while the command queue has room.
// After the last item the pair pipeline runs over the n*n, m*m and n*m row pairs
// for each of the d dimensions; drain, scaling and division then yield the result.
// The row stores are single memories with two read ports; they need no clear.
// Reset is synchronous, active low. A stalled result holds the next last item in
// the queue, and coordinates keep entering until the four-entry queue fills.
// ----------------------------------------------------------------------------
module copula_cvm_two_sample_statistic #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_DIMS  = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // coordinate[15:0]
    input  logic [0:0]  s_tuser,    // group
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // statistic[31:0]
    output logic [1:0]  m_tuser     // empty_group, rows_dropped
);

    ccvm_pkg::t_cmd       push_cmd;
    ccvm_pkg::t_cmd       pop_cmd;
    ccvm_pkg::t_back_stat bstat;
    logic                 push;
    logic                 q_full;
    logic                 q_valid;
    logic                 pop;
    logic                 empty_flag;
    logic                 drop_flag;

    ccvm_front #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_DIMS(MAX_DIMS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_grp      (s_tuser[0]),
        .i_coord    (s_tdata),
        .i_last     (s_tlast),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    ccvm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (q_full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_cmd  (pop_cmd)
    );

    ccvm_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_DIMS (MAX_DIMS),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_cmd      (pop_cmd),
        .o_pop      (pop),
        .o_out_valid(m_tvalid),
        .i_out_ready(m_tready),
        .o_stat     (m_tdata),
        .o_empty    (empty_flag),
        .o_drop     (drop_flag),
        .o_bstat    (bstat)
    );

    assign m_tuser = {drop_flag, empty_flag};

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("empty group result with nonzero statistic");

    a_busy_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        bstat.busy |-> !m_tvalid)
        else $error("result pending while computing");

endmodule
